// File: src/nsv_pkg.sv
// Package for the NMEA sentence validator: parse phases, sentence kinds,
// character and formatter constants, and the result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nsv_pkg;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_BODY,
		PH_HEX_HI,
		PH_HEX_LO,
		PH_DONE
	} nsv_phase_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_GGA  = 2'd1,
		KIND_RMC  = 2'd2,
		KIND_ZDA  = 2'd3
	} nsv_kind_t;

	localparam logic [7:0]  CHR_ASTERISK = "*";
	localparam logic [23:0] FMT_GGA      = "GGA";
	localparam logic [23:0] FMT_RMC      = "RMC";
	localparam logic [23:0] FMT_ZDA      = "ZDA";

	localparam logic [2:0] POS_FMT_FIRST = 3'd3;
	localparam logic [2:0] POS_FMT_MID   = 3'd4;
	localparam logic [2:0] POS_FMT_LAST  = 3'd5;
	localparam logic [2:0] POS_MAX       = 3'd7;

	typedef struct packed {
		logic       sum_matches;
		logic [7:0] received_sum;
		logic [7:0] computed_sum;
		nsv_kind_t  sentence_kind;
	} nsv_result_t;

endpackage

`default_nettype wire

// File: src/nmea_sentence_validator_unit.sv
// Top level of the NMEA sentence validator: input register, line parser and
// output register with stream handshakes. Depends on nsv_pkg, nsv_line_parser.
`timescale 1ns / 1ps
`default_nettype none

// Checks NMEA 0183 lines one character per item. The character after the
// first is XORed in up to the first '*'; the two hex digits after it are the
// received sum. s_tlast marks the last character of a line, and only that
// item gives a result: sentence kind (GGA, RMC, ZDA from line characters 3-5,
// or none), computed and received sums, and a match flag. One item is taken
// every cycle unless stalled; the last character of a line passes the input
// register, then its result goes to the output register. The input register
// stalls only while a finished result is held there and not taken.
module nmea_sentence_validator_unit import nsv_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // char_in[7:0]
	input  wire         s_tlast,   // line_end
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata    // sentence_kind[1:0], computed_sum[9:2],
	                               // received_sum[17:10], sum_matches[18], zero
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	logic        advance;
	logic        out_valid_q;
	nsv_result_t res_q;
	nsv_result_t res;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	nsv_line_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.char_in  (char_s1),
		.line_end (last_s1),
		.result   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_q.sum_matches, res_q.received_sum, res_q.computed_sum,
		res_q.sentence_kind};

endmodule

`default_nettype wire

// File: src/nsv_line_parser.sv
// Line parser: running XOR, phase machine, formatter capture and checksum
// digits; presents the line result for the current character.
// Depends on nsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsv_line_parser import nsv_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         step,
	input  wire  [7:0]  char_in,
	input  wire         line_end,
	output nsv_result_t result
);

	nsv_phase_t  phase_q, phase_d;
	logic [7:0]  xor_q, xor_d;
	logic [2:0]  pos_q, pos_d;
	logic [23:0] fmt_q, fmt_d;
	logic [7:0]  hex_q, hex_d;
	logic        hex_ok_q, hex_ok_d;

	logic [3:0]  digit_val;
	logic        digit_bad;
	logic [7:0]  recv;
	logic        match;

	// hex digit decode, upper or lower case
	always_comb begin
		digit_val = 4'd0;
		digit_bad = 1'b0;
		if (char_in >= "0" && char_in <= "9") begin
			digit_val = 4'(char_in - "0");
		end else if (char_in >= "A" && char_in <= "F") begin
			digit_val = 4'(char_in - "A" + 8'd10);
		end else if (char_in >= "a" && char_in <= "f") begin
			digit_val = 4'(char_in - "a" + 8'd10);
		end else begin
			digit_bad = 1'b1;
		end
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		xor_d    = xor_q;
		fmt_d    = fmt_q;
		hex_d    = hex_q;
		hex_ok_d = hex_ok_q;
		pos_d    = (pos_q == POS_MAX) ? POS_MAX : pos_q + 3'd1;

		case (pos_q)
			POS_FMT_FIRST: fmt_d[23:16] = char_in;
			POS_FMT_MID:   fmt_d[15:8]  = char_in;
			POS_FMT_LAST:  fmt_d[7:0]   = char_in;
			default:       fmt_d        = fmt_q;
		endcase

		unique case (phase_q)
			PH_FIRST: phase_d = PH_BODY;
			PH_BODY: begin
				if (char_in == CHR_ASTERISK) begin
					phase_d = PH_HEX_HI;
				end else begin
					xor_d = xor_q ^ char_in;
				end
			end
			PH_HEX_HI, PH_HEX_LO: begin
				hex_d    = {hex_q[3:0], digit_bad ? 4'd0 : digit_val};
				hex_ok_d = hex_ok_q & ~digit_bad;
				phase_d  = (phase_q == PH_HEX_HI) ? PH_HEX_LO : PH_DONE;
			end
			default: phase_d = PH_DONE;
		endcase
	end

	// line result from the updated state
	always_comb begin
		recv  = (phase_d == PH_HEX_LO) ? {hex_d[3:0], 4'd0} : hex_d;
		match = (phase_d == PH_DONE) && hex_ok_d && (recv == xor_d);
		result.sum_matches   = match;
		result.received_sum  = recv;
		result.computed_sum  = xor_d;
		result.sentence_kind = KIND_NONE;
		if (match) begin
			if (fmt_d == FMT_GGA) begin
				result.sentence_kind = KIND_GGA;
			end else if (fmt_d == FMT_RMC) begin
				result.sentence_kind = KIND_RMC;
			end else if (fmt_d == FMT_ZDA) begin
				result.sentence_kind = KIND_ZDA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			xor_q    <= 8'd0;
			pos_q    <= 3'd0;
			fmt_q    <= 24'd0;
			hex_q    <= 8'd0;
			hex_ok_q <= 1'b1;
		end else if (step) begin
			if (line_end) begin
				phase_q  <= PH_FIRST;
				xor_q    <= 8'd0;
				pos_q    <= 3'd0;
				fmt_q    <= 24'd0;
				hex_q    <= 8'd0;
				hex_ok_q <= 1'b1;
			end else begin
				phase_q  <= phase_d;
				xor_q    <= xor_d;
				pos_q    <= pos_d;
				fmt_q    <= fmt_d;
				hex_q    <= hex_d;
				hex_ok_q <= hex_ok_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: sim/nmea_sentence_validator_unit_test.sv
// Self-checking testbench for nmea_sentence_validator_unit: random and directed NMEA lines,
// a line checker class that predicts each result and compares it with the output stream.
// Depends on nsv_pkg and the validator RTL.
`timescale 1ns / 1ps

module nmea_sentence_validator_unit_test;
	import nsv_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ITEM_TARGET = 1700;
	localparam int PRINT_CAP   = 40;

	class nmea_line_checker;
		nsv_phase_t  phase;
		logic [7:0]  xor_acc;
		logic [2:0]  pos;
		logic [23:0] fmt;
		logic [7:0]  digits;
		bit          digits_ok;
		nsv_result_t expected_results[$];
		int          errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase     = PH_FIRST;
			xor_acc   = 8'h00;
			pos       = 3'd0;
			fmt       = 24'h0;
			digits    = 8'h00;
			digits_ok = 1'b1;
		endfunction

		static function logic [4:0] hex_value(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return 5'(c - "0");
			if (c >= "A" && c <= "F")
				return 5'(c - "A" + 10);
			if (c >= "a" && c <= "f")
				return 5'(c - "a" + 10);
			return 5'd16;
		endfunction

		function void take_digit(logic [7:0] c);
			logic [4:0] v;
			v = hex_value(c);
			if (v[4]) begin
				digits_ok = 1'b0;
				v = 5'd0;
			end
			digits = {digits[3:0], v[3:0]};
		endfunction

		function void note_char(logic [7:0] c, bit last);
			nsv_result_t r;
			logic [7:0]  recv;
			case (pos)
				POS_FMT_FIRST: fmt[23:16] = c;
				POS_FMT_MID:   fmt[15:8]  = c;
				POS_FMT_LAST:  fmt[7:0]   = c;
				default: ;
			endcase
			if (pos != POS_MAX)
				pos = pos + 3'd1;
			case (phase)
				PH_FIRST: phase = PH_BODY;
				PH_BODY: begin
					if (c == CHR_ASTERISK)
						phase = PH_HEX_HI;
					else
						xor_acc = xor_acc ^ c;
				end
				PH_HEX_HI: begin
					take_digit(c);
					phase = PH_HEX_LO;
				end
				PH_HEX_LO: begin
					take_digit(c);
					phase = PH_DONE;
				end
				default: phase = PH_DONE;
			endcase
			if (!last)
				return;
			recv = digits;
			if (phase == PH_HEX_LO)
				recv = {digits[3:0], 4'h0};
			r.sum_matches   = (phase == PH_DONE) && digits_ok && (recv == xor_acc);
			r.computed_sum  = xor_acc;
			r.received_sum  = recv;
			r.sentence_kind = KIND_NONE;
			if (r.sum_matches) begin
				if (fmt == FMT_GGA)
					r.sentence_kind = KIND_GGA;
				else if (fmt == FMT_RMC)
					r.sentence_kind = KIND_RMC;
				else if (fmt == FMT_ZDA)
					r.sentence_kind = KIND_ZDA;
			end
			expected_results.push_back(r);
			clear();
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [23:0] d);
			nsv_result_t e;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result %h", d));
				return;
			end
			e = expected_results.pop_front();
			if (d[1:0] !== e.sentence_kind)
				report($sformatf("sentence_kind %0d, want %0d", d[1:0], e.sentence_kind));
			if (d[9:2] !== e.computed_sum)
				report($sformatf("computed_sum %h, want %h", d[9:2], e.computed_sum));
			if (d[17:10] !== e.received_sum)
				report($sformatf("received_sum %h, want %h", d[17:10], e.received_sum));
			if (d[18] !== e.sum_matches)
				report($sformatf("sum_matches %b, want %b", d[18], e.sum_matches));
		endtask
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	nmea_line_checker line_checker = new();
	logic [7:0]       line_buf[$];
	int               items_sent = 0;
	int               cycles     = 0;

	nmea_sentence_validator_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			line_checker.check_result(m_tdata);
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver: ready bursts, sometimes long, with random stalls between
	initial begin
		int gap;
		forever begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(50, 200)) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
			gap = idle_len();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	task automatic send_line();
		int k;
		int gap;
		bit calm;
		bit last;
		calm = ($urandom_range(0, 4) == 0);
		for (k = 0; k < line_buf.size(); k++) begin
			last = (k == line_buf.size() - 1);
			gap = calm ? 0 : idle_len();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= line_buf[k];
			s_tlast  <= last;
			do @(posedge clk); while (!s_tready);
			line_checker.note_char(line_buf[k], last);
			items_sent++;
		end
		line_buf.delete();
	endtask

	task automatic load_text(string s);
		int k;
		for (k = 0; k < s.len(); k++)
			line_buf.push_back(s[k]);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
		if (v < 4'd10)
			return 8'("0" + v);
		return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
	endfunction

	task automatic append_sum(bit lower);
		int k;
		logic [7:0] sum;
		sum = 8'h00;
		for (k = 1; k < line_buf.size(); k++)
			sum = sum ^ line_buf[k];
		line_buf.push_back(CHR_ASTERISK);
		line_buf.push_back(hex_char(sum[7:4], lower));
		line_buf.push_back(hex_char(sum[3:0], lower));
	endtask

	initial begin : stimulus
		int          k;
		int          n;
		int          style;
		int          wait_left;
		logic [7:0]  c;
		logic [4:0]  hv;
		logic [7:0]  sum;
		logic [23:0] fmt;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// line ending on its first character
		load_text("$");
		send_line();
		load_text("$GPGGA");
		append_sum(1'b0);
		send_line();
		// non-dollar lead, lower-case digits, trailing character
		load_text("!GPRMC");
		append_sum(1'b1);
		line_buf.push_back(8'h0D);
		send_line();
		load_text("$GPZDA");
		append_sum(1'b0);
		send_line();
		// ends inside the checksum
		load_text("$A*4");
		send_line();
		// extreme bytes, no asterisk
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		send_line();

		while (items_sent < ITEM_TARGET) begin
			style = $urandom_range(0, 99);
			if (style < 8) begin
				n = $urandom_range(1, 30);
				repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				line_buf.push_back(($urandom_range(0, 9) == 0) ?
					8'($urandom_range(0, 255)) : 8'("$"));
				if ($urandom_range(0, 4) != 0) begin
					load_text("GP");
				end else begin
					line_buf.push_back(8'("A" + $urandom_range(0, 25)));
					line_buf.push_back(8'("A" + $urandom_range(0, 25)));
				end
				case ($urandom_range(0, 5))
					0: fmt = FMT_GGA;
					1: fmt = FMT_RMC;
					2: fmt = FMT_ZDA;
					3: fmt = {8'("A" + $urandom_range(0, 25)), 8'("A" + $urandom_range(0, 25)),
						8'("A" + $urandom_range(0, 25))};
					default: begin
						case ($urandom_range(0, 2))
							0: fmt = FMT_GGA;
							1: fmt = FMT_RMC;
							default: fmt = FMT_ZDA;
						endcase
						fmt[8 * $urandom_range(0, 2) +: 8] = 8'("A" + $urandom_range(0, 25));
					end
				endcase
				line_buf.push_back(fmt[23:16]);
				line_buf.push_back(fmt[15:8]);
				line_buf.push_back(fmt[7:0]);
				n = $urandom_range(0, 20);
				for (k = 0; k < n; k++) begin
					case ($urandom_range(0, 4))
						0: c = ",";
						1: c = ".";
						2: c = 8'("0" + $urandom_range(0, 9));
						3: c = 8'("A" + $urandom_range(0, 25));
						default: begin
							c = 8'($urandom_range(0, 255));
							if (c == CHR_ASTERISK)
								c = ",";
						end
					endcase
					line_buf.push_back(c);
				end
				sum = 8'h00;
				for (k = 1; k < line_buf.size(); k++)
					sum = sum ^ line_buf[k];
				style = $urandom_range(0, 99);
				if (style < 70) begin
					// wrong sum for part of these
					if (style >= 62)
						sum = sum ^ 8'($urandom_range(1, 255));
					line_buf.push_back(CHR_ASTERISK);
					line_buf.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
					line_buf.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
					repeat ($urandom_range(0, 2)) begin
						case ($urandom_range(0, 2))
							0: line_buf.push_back(8'h0D);
							1: line_buf.push_back(8'h0A);
							default: line_buf.push_back(8'($urandom_range(0, 255)));
						endcase
					end
				end else if (style < 77) begin
					do begin
						c = 8'($urandom_range(0, 255));
						hv = nmea_line_checker::hex_value(c);
					end while (!hv[4]);
					line_buf.push_back(CHR_ASTERISK);
					if ($urandom_range(0, 1)) begin
						line_buf.push_back(c);
						line_buf.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
					end else begin
						line_buf.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
						line_buf.push_back(c);
					end
				end else if (style < 83) begin
					// no asterisk at all
				end else if (style < 88) begin
					line_buf.push_back(CHR_ASTERISK);
				end else if (style < 93) begin
					line_buf.push_back(CHR_ASTERISK);
					line_buf.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
				end else begin
					n = $urandom_range(1, 5);
					while (line_buf.size() > n)
						void'(line_buf.pop_back());
				end
			end
			send_line();
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		while (line_checker.pending() != 0)
			@(posedge clk);
		wait_left = 10;
		while (wait_left > 0) begin
			@(posedge clk);
			wait_left--;
		end
		if (line_checker.errors == 0 && line_checker.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: nmea_sentence_validator_unit.f
src/nsv_pkg.sv
src/nsv_line_parser.sv
src/nmea_sentence_validator_unit.sv
sim/nmea_sentence_validator_unit_test.sv
